// File: src/pbfl_pkg.sv
package pbfl_pkg;

    // Request kinds carried in the action field
    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_RELEASE  = 1'b1;

    // Result codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_RETURNED  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_UNHELD    = 2'd3
    } status_t;

endpackage

// File: src/pbfl_req_if.sv
interface pbfl_req_if #(
    parameter int BUFFER_COUNT = 512
);
    localparam int IDX_W = $clog2(BUFFER_COUNT);

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] buffer_index;

    modport source (output valid, output action, output buffer_index, input ready);
    modport sink   (input valid, input action, input buffer_index, output ready);
endinterface

// File: src/pbfl_rsp_if.sv
interface pbfl_rsp_if #(
    parameter int BUFFER_COUNT = 512
);
    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam int CNT_W = $clog2(BUFFER_COUNT + 1);

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  granted_index;
    pbfl_pkg::status_t status;
    logic [CNT_W-1:0]  free_count;

    modport source (output valid, output granted_index, output status, output free_count,
                    input ready);
    modport sink   (input valid, input granted_index, input status, input free_count,
                    output ready);
endinterface

// File: src/packet_buffer_free_list.sv
// A transferred request is captured in the input stage, and its result in the result register.
// Throughput: one request per cycle while the result side keeps ready high.
// The stack top is kept in a register and the next entry below is read ahead of time,
// so back-to-back allocates never wait on the stack memory read.
// Reset: asynchronous, active low; the pool is full (index k at slot k) right after
// reset, with no clearing pass: a low-water mark stands in for untouched slots.
module packet_buffer_free_list #(
    parameter int BUFFER_COUNT = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    pbfl_req_if.sink   req,
    pbfl_rsp_if.source rsp
);
    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam int CNT_W = $clog2(BUFFER_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_COUNT);

    // Stack and held-mark memories
    logic [IDX_W-1:0] stack_mem [BUFFER_COUNT];
    logic             held_mem  [BUFFER_COUNT];

    // Input stage
    logic             s1_valid_reg;
    logic             s1_action_reg;
    logic [IDX_W-1:0] s1_index_reg;
    logic             s1_held_reg;

    // Pool state
    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] low_reg;
    logic [IDX_W-1:0] top_val_reg;
    logic             top_from_mem_reg;
    logic [IDX_W-1:0] stack_rd_reg;

    // Result register
    logic              rsp_valid_reg;
    logic [IDX_W-1:0]  rsp_granted_reg;
    pbfl_pkg::status_t rsp_status_reg;
    logic [CNT_W-1:0]  rsp_count_reg;

    logic              advance;
    logic              req_xfer;
    logic [IDX_W-1:0]  top_val;
    logic              is_release;
    logic [CNT_W-1:0]  idx_ext;
    logic              held;
    logic              alloc_ok;
    logic              rel_ok;
    logic [CNT_W-1:0]  pop_pos;
    logic [CNT_W-1:0]  top_next;
    logic [CNT_W-1:0]  low_next;
    logic [IDX_W-1:0]  granted_next;
    pbfl_pkg::status_t status_next;
    logic              held_we;
    logic [IDX_W-1:0]  held_waddr;
    logic              held_wdata;

    // Handshake: the result register parts the two sides
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    // Current top of stack, either a plain register or the last stack read
    assign top_val = top_from_mem_reg ? stack_rd_reg : top_val_reg;

    // Decode the pending request
    assign is_release = (s1_action_reg == pbfl_pkg::ACT_RELEASE);
    assign idx_ext    = CNT_W'(s1_index_reg);
    // An index below the low-water mark was never handed out, so it is not held
    assign held       = (idx_ext < FULL_COUNT) && (idx_ext >= low_reg) && s1_held_reg;
    assign alloc_ok   = !is_release && (top_reg != '0);
    assign rel_ok     = is_release && held && (top_reg < FULL_COUNT);
    assign pop_pos    = top_reg - CNT_W'(2);

    // Work out the pool update and the result
    always_comb
    begin
        top_next     = top_reg;
        low_next     = low_reg;
        granted_next = '0;
        held_waddr   = s1_index_reg;
        held_wdata   = 1'b0;
        if (alloc_ok)
        begin
            top_next     = top_reg - CNT_W'(1);
            low_next     = (top_next < low_reg) ? top_next : low_reg;
            granted_next = top_val;
            held_waddr   = top_val;
            held_wdata   = 1'b1;
            status_next  = pbfl_pkg::ST_ALLOCATED;
        end
        else if (rel_ok)
        begin
            top_next    = top_reg + CNT_W'(1);
            status_next = pbfl_pkg::ST_RETURNED;
        end
        else if (!is_release)
        begin
            status_next = pbfl_pkg::ST_EMPTY;
        end
        else
        begin
            status_next = pbfl_pkg::ST_UNHELD;
        end
    end

    assign held_we = advance && (alloc_ok || rel_ok);

    // Push onto the stack, and read the slot below the top ahead of time; hold the
    // read while the pipeline stalls so the forwarded top stays valid
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (rel_ok)
            begin
                stack_mem[top_reg[IDX_W-1:0]] <= s1_index_reg;
            end
            stack_rd_reg <= stack_mem[pop_pos[IDX_W-1:0]];
        end
    end

    // Update held marks; read the mark of an incoming index with bypass
    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_waddr] <= held_wdata;
        end
        if (req_xfer)
        begin
            if (held_we && (held_waddr == req.buffer_index))
            begin
                s1_held_reg <= held_wdata;
            end
            else
            begin
                s1_held_reg <= held_mem[req.buffer_index];
            end
        end
    end

    // Capture request payload
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_action_reg <= req.action;
            s1_index_reg  <= req.buffer_index;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_granted_reg <= granted_next;
            rsp_status_reg  <= status_next;
            rsp_count_reg   <= top_next;
        end
    end

    // Control state and pool pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            top_reg          <= FULL_COUNT;
            low_reg          <= FULL_COUNT;
            top_val_reg      <= IDX_W'(BUFFER_COUNT - 1);
            top_from_mem_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                top_reg <= top_next;
                low_reg <= low_next;
                if (alloc_ok)
                begin
                    // Slots below the low-water mark still hold their own index
                    if (pop_pos < low_next)
                    begin
                        top_val_reg      <= pop_pos[IDX_W-1:0];
                        top_from_mem_reg <= 1'b0;
                    end
                    else
                    begin
                        top_from_mem_reg <= 1'b1;
                    end
                end
                else if (rel_ok)
                begin
                    top_val_reg      <= s1_index_reg;
                    top_from_mem_reg <= 1'b0;
                end
                else
                begin
                    top_val_reg      <= top_val;
                    top_from_mem_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.granted_index = rsp_granted_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.free_count    = rsp_count_reg;

`ifndef SYNTH
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= FULL_COUNT)
        else $error("free count beyond pool size");

    a_low_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= top_reg)
        else $error("low-water mark above stack top");

    a_pop_moves_top: assert property (@(posedge clk) disable iff (!rst_n)
        advance && alloc_ok |=> top_reg == $past(top_reg) - CNT_W'(1))
        else $error("allocate did not pop the stack");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_count_reg == top_reg)
        else $error("reported free count differs from stack top");

    a_fail_holds_top: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !alloc_ok && !rel_ok |=> $stable(top_reg) && $stable(low_reg))
        else $error("rejected request changed the pool");
`endif

endmodule
